// ----- rtl/ecu_pkg.sv -----
// ---------------------------------------------------------------------------
// ecu_pkg: shared types, constants and table contents for the easing unit
// Fixed-point formats, curve codes, and the 2^-f and quarter-sine tables in
// Q1.30, built once at elaboration.
// ---------------------------------------------------------------------------
`default_nettype none

package ecu_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int TABLE_ADDR_BITS = 8;

  // Q0.F / Q1.F values, 0..one inclusive
  localparam int X_W    = FRAC_BITS + 1;
  // 10 * t, t <= one
  localparam int D_W    = FRAC_BITS + 4;
  localparam int N_W    = D_W - FRAC_BITS;
  localparam int P_W    = X_W + TABLE_ADDR_BITS;
  localparam int IDX_W  = TABLE_ADDR_BITS + 1;
  localparam int TAB_LEN = (1 << TABLE_ADDR_BITS) + 1;
  localparam int ROM_W  = 31;
  localparam int SH_W   = 6;
  localparam int SUM_W  = ROM_W + 2;
  localparam int SH_BASE = 30 - FRAC_BITS;

  localparam int MODE_W       = 4;
  localparam int IN_TDATA_W   = ((X_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((X_W + 7) / 8) * 8;

  localparam logic [X_W-1:0] ONE  = X_W'(1) << FRAC_BITS;
  localparam logic [X_W-1:0] HALF = X_W'(1) << (FRAC_BITS - 1);

  // curve selector codes
  localparam logic [MODE_W-1:0] MODE_QUAD_IN     = 4'd0;
  localparam logic [MODE_W-1:0] MODE_QUAD_OUT    = 4'd1;
  localparam logic [MODE_W-1:0] MODE_QUAD_INOUT  = 4'd2;
  localparam logic [MODE_W-1:0] MODE_CUBIC_IN    = 4'd3;
  localparam logic [MODE_W-1:0] MODE_CUBIC_OUT   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_CUBIC_INOUT = 4'd5;
  localparam logic [MODE_W-1:0] MODE_EXPO_IN     = 4'd6;
  localparam logic [MODE_W-1:0] MODE_EXPO_OUT    = 4'd7;
  localparam logic [MODE_W-1:0] MODE_EXPO_INOUT  = 4'd8;
  localparam logic [MODE_W-1:0] MODE_SINE_IN     = 4'd9;
  localparam logic [MODE_W-1:0] MODE_SINE_OUT    = 4'd10;
  localparam logic [MODE_W-1:0] MODE_SINE_INOUT  = 4'd11;

  typedef enum logic [1:0] {
    FAM_QUAD,
    FAM_CUBIC,
    FAM_EXPO,
    FAM_SINE
  } fam_t;

  typedef enum logic [1:0] {
    KIND_IN,
    KIND_OUT,
    KIND_INOUT
  } kind_t;

  // stage enables handed to the table/interpolation pipe
  typedef struct packed {
    logic en_a;
    logic en_b;
  } lerp_ctl_t;

  typedef logic [ROM_W-1:0] rom_t [TAB_LEN];

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] LN2_Q30     = 64'd744261118;

  // (2j)(2j+1) for the sine series terms, j = 1..7
  localparam logic [63:0] SIN_DIV [7] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

  function automatic logic [63:0] mul30(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  // sin(theta), theta in Q30 over 0..pi/2, truncated Taylor series
  function automatic logic [63:0] gen_sin(input logic [63:0] theta);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    logic [63:0] t2;
    pos  = theta;
    neg  = 64'd0;
    term = theta;
    t2   = mul30(theta, theta);
    for (int j = 1; j <= 7; j++) begin
      term = mul30(term, t2) / SIN_DIV[j-1];
      if (j % 2 == 1) neg = neg + term;
      else            pos = pos + term;
    end
    pos = (pos > neg) ? pos - neg : 64'd0;
    return (pos > Q30_ONE) ? Q30_ONE : pos;
  endfunction

  // e^-y, y in Q30 below one
  function automatic logic [63:0] gen_exp_neg(input logic [63:0] y);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    pos  = Q30_ONE;
    neg  = 64'd0;
    term = Q30_ONE;
    for (int j = 1; j <= 12; j++) begin
      term = mul30(term, y) / 64'(j);
      if (j % 2 == 1) neg = neg + term;
      else            pos = pos + term;
    end
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  function automatic rom_t build_sin_rom();
    rom_t t;
    logic [63:0] theta;
    for (int i = 0; i < TAB_LEN; i++) begin
      theta = (HALF_PI_Q30 * 64'(i)) >> TABLE_ADDR_BITS;
      t[i]  = ROM_W'(gen_sin(theta));
    end
    return t;
  endfunction

  function automatic rom_t build_exp_rom();
    rom_t t;
    logic [63:0] f30;
    for (int i = 0; i < TAB_LEN; i++) begin
      f30  = (64'(i) << 30) >> TABLE_ADDR_BITS;
      t[i] = ROM_W'(gen_exp_neg(mul30(f30, LN2_Q30)));
    end
    return t;
  endfunction

  localparam rom_t SIN_ROM = build_sin_rom();
  localparam rom_t EXP_ROM = build_exp_rom();

endpackage

`default_nettype wire

// ----- rtl/ecu_lerp.sv -----
// ---------------------------------------------------------------------------
// ecu_lerp: table lookup and linear interpolation
// Two register stages: neighbor fetch and step, then step times fraction.
// ---------------------------------------------------------------------------
`default_nettype none

module ecu_lerp
  import ecu_pkg::*;
(
  input  wire logic                 clk,
  input  wire lerp_ctl_t            ctl,
  input  wire logic                 use_exp,
  input  wire logic [IDX_W-1:0]     idx,
  input  wire logic [FRAC_BITS-1:0] fr,
  output logic      [ROM_W-1:0]     v30
);

  logic                 at_end;
  logic [IDX_W-1:0]     idx_hi;
  logic [ROM_W-1:0]     lo_val;
  logic [ROM_W-1:0]     hi_val;
  logic [ROM_W-1:0]     base_nxt;
  logic [ROM_W-1:0]     diff_nxt;
  logic                 dn_nxt;
  logic [ROM_W-1:0]     base_r;
  logic [ROM_W-1:0]     diff_r;
  logic                 dn_r;
  logic [FRAC_BITS-1:0] fr_r;
  logic [ROM_W+FRAC_BITS-1:0] prod;
  logic [ROM_W-1:0]     step;
  logic [ROM_W-1:0]     v30_nxt;
  logic [ROM_W-1:0]     v30_r;

  // stage A: fetch both neighbors; the last entry stands alone
  always_comb begin
    at_end   = (idx >= IDX_W'(TAB_LEN - 1));
    idx_hi   = at_end ? idx : idx + IDX_W'(1);
    lo_val   = use_exp ? EXP_ROM[idx]    : SIN_ROM[idx];
    hi_val   = use_exp ? EXP_ROM[idx_hi] : SIN_ROM[idx_hi];
    base_nxt = lo_val;
    dn_nxt   = (hi_val < lo_val);
    diff_nxt = dn_nxt ? lo_val - hi_val : hi_val - lo_val;
  end

  always_ff @(posedge clk) begin
    if (ctl.en_a) begin
      base_r <= base_nxt;
      diff_r <= diff_nxt;
      dn_r   <= dn_nxt;
      fr_r   <= fr;
    end
  end

  // stage B: truncated step, applied toward the upper neighbor
  always_comb begin
    prod    = (ROM_W+FRAC_BITS)'(diff_r) * (ROM_W+FRAC_BITS)'(fr_r);
    step    = prod[ROM_W+FRAC_BITS-1:FRAC_BITS];
    v30_nxt = dn_r ? base_r - step : base_r + step;
  end

  always_ff @(posedge clk) begin
    if (ctl.en_b) begin
      v30_r <= v30_nxt;
    end
  end

  assign v30 = v30_r;

endmodule

`default_nettype wire

// ----- rtl/easing_curve_unit.sv -----
// ---------------------------------------------------------------------------
// easing_curve_unit: quad, cubic, exponential and sine easing curves
// Five-stage pipeline from progress value and curve code to eased value.
// ---------------------------------------------------------------------------
// Takes one item per clock while out_tready does not stall the pipe, and
// returns its eased value through registers for decode, table fetch and
// square, interpolate and cube, rounding, and final compose. Every stage
// holds a valid bit and moves on when the stage ahead is empty or moving, so
// bubbles close up and out_tready low stalls only as far back as needed. The
// 2^-f and sine tables are constant logic; there is no state to initialize.
`default_nettype none

module easing_curve_unit
  import ecu_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [16:0] position
  input  wire logic [MODE_W-1:0]      in_tuser,   // [3:0] mode
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata   // [16:0] eased
);

  // handshake chain
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5      = !out_valid_r || out_tready;
  assign rdy4      = !s4_valid_r || rdy5;
  assign rdy3      = !s3_valid_r || rdy4;
  assign rdy2      = !s2_valid_r || rdy3;
  assign rdy1      = !s1_valid_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) s1_valid_r  <= in_tvalid;
      if (rdy2) s2_valid_r  <= s1_valid_r;
      if (rdy3) s3_valid_r  <= s2_valid_r;
      if (rdy4) s4_valid_r  <= s3_valid_r;
      if (rdy5) out_valid_r <= s4_valid_r;
    end
  end

  // ---------------- stage 1: decode and argument forming ----------------
  logic [X_W-1:0]       pos_in;
  logic [X_W-1:0]       x_sat;
  fam_t                 fam;
  kind_t                kind;
  logic                 bad;
  logic                 lower;
  logic                 eff_in;
  logic [X_W:0]         x2;
  logic [X_W-1:0]       xe;
  logic [X_W-1:0]       comp;
  logic [X_W-1:0]       targ;
  logic [D_W-1:0]       d;
  logic [X_W-1:0]       u;
  logic [P_W-1:0]       p;

  fam_t                 s1_fam_nxt;
  logic                 s1_inv_nxt, s1_half_nxt, s1_lower_nxt;
  logic                 s1_fz_nxt, s1_fo_nxt, s1_bad_nxt;
  logic [X_W-1:0]       s1_pa_nxt;
  logic [N_W-1:0]       s1_n_nxt;
  logic [IDX_W-1:0]     s1_idx_nxt;
  logic [FRAC_BITS-1:0] s1_fr_nxt;

  always_comb begin
    pos_in = in_tdata[X_W-1:0];
    x_sat  = (pos_in > ONE) ? ONE : pos_in;
    fam    = FAM_QUAD;
    kind   = KIND_IN;
    bad    = 1'b0;
    case (in_tuser)
      MODE_QUAD_IN:     begin fam = FAM_QUAD;  kind = KIND_IN;    end
      MODE_QUAD_OUT:    begin fam = FAM_QUAD;  kind = KIND_OUT;   end
      MODE_QUAD_INOUT:  begin fam = FAM_QUAD;  kind = KIND_INOUT; end
      MODE_CUBIC_IN:    begin fam = FAM_CUBIC; kind = KIND_IN;    end
      MODE_CUBIC_OUT:   begin fam = FAM_CUBIC; kind = KIND_OUT;   end
      MODE_CUBIC_INOUT: begin fam = FAM_CUBIC; kind = KIND_INOUT; end
      MODE_EXPO_IN:     begin fam = FAM_EXPO;  kind = KIND_IN;    end
      MODE_EXPO_OUT:    begin fam = FAM_EXPO;  kind = KIND_OUT;   end
      MODE_EXPO_INOUT:  begin fam = FAM_EXPO;  kind = KIND_INOUT; end
      MODE_SINE_IN:     begin fam = FAM_SINE;  kind = KIND_IN;    end
      MODE_SINE_OUT:    begin fam = FAM_SINE;  kind = KIND_OUT;   end
      MODE_SINE_INOUT:  begin fam = FAM_SINE;  kind = KIND_INOUT; end
      default:          bad = 1'b1;
    endcase

    lower  = (x_sat < HALF);
    eff_in = (kind == KIND_IN) || ((kind == KIND_INOUT) && lower);
    x2     = {x_sat, 1'b0};
    if (kind == KIND_INOUT) begin
      xe = lower ? X_W'(x2) : X_W'(x2 - {1'b0, ONE});
    end else begin
      xe = x_sat;
    end
    comp = ONE - xe;

    // table argument: exp uses 10*(one-x) for in, 10*x for out;
    // sine uses one-x for in, x for out
    targ = eff_in ? comp : xe;
    d    = D_W'({targ, 3'b000}) + D_W'({targ, 1'b0});
    u    = (fam == FAM_EXPO) ? X_W'(d[FRAC_BITS-1:0]) : targ;
    p    = P_W'(u) << TABLE_ADDR_BITS;

    s1_fam_nxt   = fam;
    s1_inv_nxt   = (fam == FAM_SINE) ? eff_in : !eff_in;
    s1_half_nxt  = (kind == KIND_INOUT);
    s1_lower_nxt = lower;
    s1_fz_nxt    = (fam == FAM_EXPO) && eff_in && (xe == '0);
    s1_fo_nxt    = (fam == FAM_EXPO) && !eff_in && (xe >= ONE);
    s1_bad_nxt   = bad;
    s1_pa_nxt    = eff_in ? xe : comp;
    s1_n_nxt     = (fam == FAM_EXPO) ? d[D_W-1:FRAC_BITS] : '0;
    s1_idx_nxt   = p[FRAC_BITS+TABLE_ADDR_BITS:FRAC_BITS];
    s1_fr_nxt    = p[FRAC_BITS-1:0];
  end

  fam_t                 s1_fam_r;
  logic                 s1_inv_r, s1_half_r, s1_lower_r, s1_fz_r, s1_fo_r, s1_bad_r;
  logic [X_W-1:0]       s1_pa_r;
  logic [N_W-1:0]       s1_n_r;
  logic [IDX_W-1:0]     s1_idx_r;
  logic [FRAC_BITS-1:0] s1_fr_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_fam_r   <= s1_fam_nxt;
      s1_inv_r   <= s1_inv_nxt;
      s1_half_r  <= s1_half_nxt;
      s1_lower_r <= s1_lower_nxt;
      s1_fz_r    <= s1_fz_nxt;
      s1_fo_r    <= s1_fo_nxt;
      s1_bad_r   <= s1_bad_nxt;
      s1_pa_r    <= s1_pa_nxt;
      s1_n_r     <= s1_n_nxt;
      s1_idx_r   <= s1_idx_nxt;
      s1_fr_r    <= s1_fr_nxt;
    end
  end

  // ---------------- stages 2 and 3: table interpolation ----------------
  lerp_ctl_t        lerp_ctl;
  logic [ROM_W-1:0] lerp_v30;

  assign lerp_ctl.en_a = rdy2;
  assign lerp_ctl.en_b = rdy3;

  ecu_lerp u_lerp (
    .clk     (clk),
    .ctl     (lerp_ctl),
    .use_exp (s1_fam_r == FAM_EXPO),
    .idx     (s1_idx_r),
    .fr      (s1_fr_r),
    .v30     (lerp_v30)
  );

  // ---------------- stage 2: square ----------------
  logic [2*X_W-1:0] sq_sum;
  logic [X_W-1:0]   s2_sq_nxt;

  always_comb begin
    sq_sum    = ((2*X_W)'(s1_pa_r) * (2*X_W)'(s1_pa_r)) + (2*X_W)'(HALF);
    s2_sq_nxt = sq_sum[FRAC_BITS+X_W-1:FRAC_BITS];
  end

  fam_t           s2_fam_r;
  logic           s2_inv_r, s2_half_r, s2_lower_r, s2_fz_r, s2_fo_r, s2_bad_r;
  logic [X_W-1:0] s2_pa_r;
  logic [X_W-1:0] s2_sq_r;
  logic [N_W-1:0] s2_n_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_fam_r   <= s1_fam_r;
      s2_inv_r   <= s1_inv_r;
      s2_half_r  <= s1_half_r;
      s2_lower_r <= s1_lower_r;
      s2_fz_r    <= s1_fz_r;
      s2_fo_r    <= s1_fo_r;
      s2_bad_r   <= s1_bad_r;
      s2_pa_r    <= s1_pa_r;
      s2_sq_r    <= s2_sq_nxt;
      s2_n_r     <= s1_n_r;
    end
  end

  // ---------------- stage 3: cube ----------------
  logic [2*X_W-1:0] cu_sum;
  logic [X_W-1:0]   s3_poly_nxt;

  always_comb begin
    cu_sum      = ((2*X_W)'(s2_sq_r) * (2*X_W)'(s2_pa_r)) + (2*X_W)'(HALF);
    s3_poly_nxt = (s2_fam_r == FAM_CUBIC) ? cu_sum[FRAC_BITS+X_W-1:FRAC_BITS] : s2_sq_r;
  end

  fam_t           s3_fam_r;
  logic           s3_inv_r, s3_half_r, s3_lower_r, s3_fz_r, s3_fo_r, s3_bad_r;
  logic [X_W-1:0] s3_poly_r;
  logic [N_W-1:0] s3_n_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_fam_r   <= s2_fam_r;
      s3_inv_r   <= s2_inv_r;
      s3_half_r  <= s2_half_r;
      s3_lower_r <= s2_lower_r;
      s3_fz_r    <= s2_fz_r;
      s3_fo_r    <= s2_fo_r;
      s3_bad_r   <= s2_bad_r;
      s3_poly_r  <= s3_poly_nxt;
      s3_n_r     <= s2_n_r;
    end
  end

  // ---------------- stage 4: round table value to Q.F ----------------
  logic [SH_W-1:0]  sh;
  logic [SUM_W-1:0] rnd;
  logic [SUM_W-1:0] rsum;
  logic [SUM_W-1:0] rshift;
  logic [X_W-1:0]   s4_cv_nxt;

  always_comb begin
    // 2^-n folds into the rounding shift
    sh        = SH_W'(SH_BASE) + SH_W'(s3_n_r);
    rnd       = SUM_W'(1) << (sh - SH_W'(1));
    rsum      = SUM_W'(lerp_v30) + rnd;
    rshift    = rsum >> sh;
    s4_cv_nxt = (s3_fam_r == FAM_QUAD || s3_fam_r == FAM_CUBIC) ?
                s3_poly_r : X_W'(rshift);
  end

  logic           s4_inv_r, s4_half_r, s4_lower_r, s4_fz_r, s4_fo_r, s4_bad_r;
  logic [X_W-1:0] s4_cv_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_inv_r   <= s3_inv_r;
      s4_half_r  <= s3_half_r;
      s4_lower_r <= s3_lower_r;
      s4_fz_r    <= s3_fz_r;
      s4_fo_r    <= s3_fo_r;
      s4_bad_r   <= s3_bad_r;
      s4_cv_r    <= s4_cv_nxt;
    end
  end

  // ---------------- stage 5: compose and output register ----------------
  logic [X_W-1:0] r0;
  logic [X_W-1:0] hv;
  logic [X_W-1:0] r1;
  logic [X_W-1:0] eased_nxt;
  logic [X_W-1:0] eased_r;

  always_comb begin
    r0 = s4_inv_r ? ONE - s4_cv_r : s4_cv_r;
    if (s4_fz_r) r0 = '0;
    if (s4_fo_r) r0 = ONE;
    hv = {1'b0, r0[X_W-1:1]};
    if (s4_half_r) begin
      r1 = s4_lower_r ? hv : hv + HALF;
    end else begin
      r1 = r0;
    end
    eased_nxt = (r1 > ONE) ? ONE : r1;
    if (s4_bad_r) eased_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      eased_r <= eased_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(eased_r);

`ifndef SYNTHESIS
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (eased_r <= ONE))
    else $error("eased value above one");

  a_s4_range: assert property (@(posedge clk) disable iff (!rst_n)
    s4_valid_r |-> (s4_cv_r <= ONE))
    else $error("curve value above one before compose");

  a_s4_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_valid_r && !rdy5) |=> (s4_valid_r && $stable(s4_cv_r)))
    else $error("stalled item lost or changed in stage 4");

  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for easing_curve_unit
// Drives progress values and curve codes over the input stream, predicts each
// eased value with a local fixed-point model (own 2^-f and sine tables), and
// compares every output item in order. Sender bursts and receiver stalls vary.
// ---------------------------------------------------------------------------
module tb_top;
  import ecu_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RAND_ITEMS   = 750;
  localparam int TAIL_CYCLES  = 20;
  localparam int N_DIR        = 25;

  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 4'd12;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 4'd15;

  localparam logic [63:0] UNIT    = 64'(ONE);
  localparam logic [63:0] HALF_U  = 64'(HALF);
  localparam logic [63:0] Q30     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI = 64'd1686629713;
  localparam logic [63:0] LN2     = 64'd744261118;

  typedef struct packed {
    logic [X_W-1:0]    pos;
    logic [MODE_W-1:0] mode;
    logic              known;
    logic [X_W-1:0]    want;
  } stim_row_t;

  typedef struct packed {
    logic [X_W-1:0]    pos;
    logic [MODE_W-1:0] mode;
    logic [X_W-1:0]    eased;
  } eased_exp_t;

  // known rows carry the value read straight off the curve definitions
  localparam stim_row_t DIR_ROWS [N_DIR] = '{
    {17'd0,          MODE_QUAD_IN,     1'b1, 17'd0},
    {ONE,            MODE_QUAD_IN,     1'b1, ONE},
    {17'd0,          MODE_QUAD_OUT,    1'b1, 17'd0},
    {ONE,            MODE_QUAD_OUT,    1'b1, ONE},
    {HALF,           MODE_QUAD_INOUT,  1'b0, 17'd0},
    {HALF - 17'd1,   MODE_QUAD_INOUT,  1'b0, 17'd0},
    {17'd0,          MODE_CUBIC_IN,    1'b1, 17'd0},
    {ONE,            MODE_CUBIC_IN,    1'b1, ONE},
    {17'd1,          MODE_CUBIC_OUT,   1'b0, 17'd0},
    {ONE,            MODE_CUBIC_INOUT, 1'b1, ONE},
    {17'd0,          MODE_EXPO_IN,     1'b1, 17'd0},
    {ONE,            MODE_EXPO_IN,     1'b0, 17'd0},
    {17'd1,          MODE_EXPO_IN,     1'b0, 17'd0},
    {ONE,            MODE_EXPO_OUT,    1'b1, ONE},
    {17'd0,          MODE_EXPO_OUT,    1'b0, 17'd0},
    {17'd0,          MODE_EXPO_INOUT,  1'b1, 17'd0},
    {HALF,           MODE_EXPO_INOUT,  1'b0, 17'd0},
    {17'd0,          MODE_SINE_IN,     1'b0, 17'd0},
    {ONE,            MODE_SINE_OUT,    1'b0, 17'd0},
    {17'd0,          MODE_SINE_OUT,    1'b1, 17'd0},
    {17'h1FFFF,      MODE_SINE_INOUT,  1'b0, 17'd0},
    {17'h1FFFF,      MODE_QUAD_IN,     1'b1, ONE},
    {ONE + 17'd1,    MODE_CUBIC_OUT,   1'b1, ONE},
    {17'd12345,      MODE_SPARE_FIRST, 1'b1, 17'd0},
    {17'h1FFFF,      MODE_SPARE_LAST,  1'b1, 17'd0}
  };

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [16:0] position
  logic [MODE_W-1:0]      in_tuser   = '0;   // [3:0] mode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [16:0] eased

  // side tags riding along with each input item
  logic                   tag_known  = 1'b0;
  logic [X_W-1:0]         tag_want   = '0;

  logic [63:0]  sine_tab [TAB_LEN];
  logic [63:0]  expo_tab [TAB_LEN];
  eased_exp_t   eased_due [$];
  int           mismatch_cnt = 0;
  int           cycle_cnt    = 0;
  int           burst_left   = 0;

  easing_curve_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------- fixed-point curve model ----------------
  function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  function automatic logic [63:0] sine_series(input logic [63:0] theta);
    logic [63:0] acc_p;
    logic [63:0] acc_n;
    logic [63:0] term;
    logic [63:0] sq;
    int          k;
    acc_p = theta;
    acc_n = 64'd0;
    term  = theta;
    sq    = q30_mul(theta, theta);
    for (k = 1; k <= 7; k++) begin
      term = q30_mul(term, sq) / (64'(2 * k) * 64'(2 * k + 1));
      if (k % 2 == 1) acc_n += term;
      else acc_p += term;
    end
    acc_p = (acc_p > acc_n) ? acc_p - acc_n : 64'd0;
    return (acc_p > Q30) ? Q30 : acc_p;
  endfunction

  function automatic logic [63:0] exp_series(input logic [63:0] y);
    logic [63:0] acc_p;
    logic [63:0] acc_n;
    logic [63:0] term;
    int          k;
    acc_p = Q30;
    acc_n = 64'd0;
    term  = Q30;
    for (k = 1; k <= 12; k++) begin
      term = q30_mul(term, y) / 64'(k);
      if (k % 2 == 1) acc_n += term;
      else acc_p += term;
    end
    return (acc_p > acc_n) ? acc_p - acc_n : 64'd0;
  endfunction

  // linear interpolation into the sine or 2^-f table, u in Q1.16 (0..one)
  function automatic logic [63:0] tab_lerp(input bit use_sine, input logic [63:0] u);
    logic [63:0] p;
    logic [63:0] idx;
    logic [63:0] fr;
    logic [63:0] lo;
    logic [63:0] hi;
    p   = u << TABLE_ADDR_BITS;
    idx = p >> FRAC_BITS;
    fr  = p & (UNIT - 64'd1);
    if (idx >= 64'(TAB_LEN - 1)) return use_sine ? sine_tab[TAB_LEN-1] : expo_tab[TAB_LEN-1];
    lo = use_sine ? sine_tab[idx] : expo_tab[idx];
    hi = use_sine ? sine_tab[idx+1] : expo_tab[idx+1];
    if (hi >= lo) return lo + (((hi - lo) * fr) >> FRAC_BITS);
    return lo - (((lo - hi) * fr) >> FRAC_BITS);
  endfunction

  function automatic logic [63:0] q30_round(input logic [63:0] v, input int extra);
    int sh;
    sh = 30 - FRAC_BITS + extra;
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic logic [63:0] pow2_frac(input logic [63:0] d);
    return q30_round(tab_lerp(1'b0, d & (UNIT - 64'd1)), int'(d >> FRAC_BITS));
  endfunction

  function automatic logic [63:0] poly_rise(input fam_t fam, input logic [63:0] x);
    logic [63:0] sq;
    sq = (x * x + HALF_U) >> FRAC_BITS;
    if (fam == FAM_QUAD) return sq;
    return (sq * x + HALF_U) >> FRAC_BITS;
  endfunction

  function automatic logic [63:0] ease_in(input fam_t fam, input logic [63:0] x);
    case (fam)
      FAM_QUAD, FAM_CUBIC: return poly_rise(fam, x);
      FAM_EXPO: return (x == 64'd0) ? 64'd0 : pow2_frac(64'd10 * (UNIT - x));
      default: return UNIT - q30_round(tab_lerp(1'b1, UNIT - x), 0);
    endcase
  endfunction

  function automatic logic [63:0] ease_out(input fam_t fam, input logic [63:0] x);
    case (fam)
      FAM_QUAD, FAM_CUBIC: return UNIT - poly_rise(fam, UNIT - x);
      FAM_EXPO: return (x >= UNIT) ? UNIT : UNIT - pow2_frac(64'd10 * x);
      default: return q30_round(tab_lerp(1'b1, x), 0);
    endcase
  endfunction

  function automatic logic [X_W-1:0] ease_value(input logic [X_W-1:0] pos,
                                                input logic [MODE_W-1:0] mode);
    logic [63:0] x;
    logic [63:0] r;
    fam_t        fam;
    kind_t       kind;
    x    = (pos > ONE) ? UNIT : 64'(pos);
    fam  = fam_t'(mode / 4'd3);
    kind = kind_t'(mode % 4'd3);
    if (mode > MODE_SINE_INOUT) r = 64'd0;
    else if (kind == KIND_IN) r = ease_in(fam, x);
    else if (kind == KIND_OUT) r = ease_out(fam, x);
    else if (x < HALF_U) r = ease_in(fam, 2 * x) >> 1;
    else r = (ease_out(fam, 2 * x - UNIT) >> 1) + HALF_U;
    if (r > UNIT) r = UNIT;
    return r[X_W-1:0];
  endfunction

  // ---------------- sender ----------------
  task automatic send_item(input logic [X_W-1:0] pos, input logic [MODE_W-1:0] mode,
                           input logic known, input logic [X_W-1:0] want);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(pos);
    in_tuser  <= mode;
    tag_known <= known;
    tag_want  <= want;
    do @(posedge clk); while (!in_tready);
  endtask

  // bursts of random length, random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (eased_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [63:0]       f30;
    logic [X_W-1:0]    pos;
    logic [MODE_W-1:0] mode;
    int                pick;
    for (int i = 0; i < TAB_LEN; i++) begin
      f30         = (64'(i) << 30) >> TABLE_ADDR_BITS;
      sine_tab[i] = sine_series((HALF_PI * 64'(i)) >> TABLE_ADDR_BITS);
      expo_tab[i] = exp_series(q30_mul(f30, LN2));
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      send_item(DIR_ROWS[i].pos, DIR_ROWS[i].mode, DIR_ROWS[i].known, DIR_ROWS[i].want);
      pace_sender();
    end
    drain_results();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        pos = X_W'($urandom_range(0, 65536));
      end else if (pick < 88) begin
        case ($urandom_range(0, 5))
          0: pos = '0;
          1: pos = 17'd1;
          2: pos = HALF - 17'd1;
          3: pos = HALF;
          4: pos = ONE - 17'd1;
          default: pos = ONE;
        endcase
      end else begin
        pos = X_W'($urandom_range(65537, 131071));
      end
      if ($urandom_range(0, 99) < 8) mode = MODE_W'($urandom_range(MODE_SPARE_FIRST,
                                                                   MODE_SPARE_LAST));
      else mode = MODE_W'($urandom_range(MODE_QUAD_IN, MODE_SINE_INOUT));
      send_item(pos, mode, 1'b0, '0);
      // hold off mid-run until the pipe is empty
      if (i == RAND_ITEMS / 2) drain_results();
      else pace_sender();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && eased_due.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // ---------------- receiver: stall pattern changes every stretch ----------------
  int rx_style = 0;
  int rx_left  = 0;
  int rx_phase = 0;
  int rx_per   = 4;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_style <= $urandom_range(0, 3);
      rx_left  <= $urandom_range(30, 200);
      rx_per   <= $urandom_range(2, 16);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_phase <= rx_phase + 1;
    case (rx_style)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ((rx_phase % rx_per) < (rx_per / 2));
    endcase
  end

  // ---------------- scoreboard ----------------
  always @(posedge clk) begin
    eased_exp_t e;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        e.pos   = in_tdata[X_W-1:0];
        e.mode  = in_tuser;
        e.eased = tag_known ? tag_want : ease_value(in_tdata[X_W-1:0], in_tuser);
        eased_due.push_back(e);
      end
      if (out_tvalid && out_tready) begin
        if (eased_due.size() == 0) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("[%0t] unexpected output item: eased %0d", $realtime,
                     out_tdata[X_W-1:0]);
        end else begin
          e = eased_due.pop_front();
          if (out_tdata[X_W-1:0] !== e.eased) begin
            mismatch_cnt <= mismatch_cnt + 1;
            if (mismatch_cnt < 10)
              $display("[%0t] eased mismatch (pos %0d mode %0d): expected %0d actual %0d",
                       $realtime, e.pos, e.mode, e.eased, out_tdata[X_W-1:0]);
          end
        end
      end
    end
  end

  initial begin
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("Verification failed");
    $finish;
  end

endmodule
